// ===== rtl/core/uartbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART baud divisor check package
// Widths, status codes, line setting codes and the item record that travels
// down the divisor check pipeline.
// ----------------------------------------------------------------------------
package uartbd_pkg;

  localparam int SPEED_W   = 32;
  localparam int CFG_W     = 32;
  localparam int OVS_SHIFT = 4;
  localparam int CLK_W     = CFG_W - OVS_SHIFT;
  localparam int DIV_W     = 16;
  localparam int DIFF_W    = SPEED_W;
  localparam int PROD_W    = DIFF_W + 6;

  localparam int unsigned TOL_DIVISOR = 30;

  localparam logic [3:0] WORD_MIN = 4'd5;
  localparam logic [3:0] WORD_MAX = 4'd8;

  localparam logic [1:0] PARITY_UNSUPPORTED = 2'd3;
  localparam logic [1:0] STOP_ONE           = 2'd0;
  localparam logic [1:0] STOP_TWO           = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SPEED  = 3'd1,
    ST_BAD_PARITY = 3'd2,
    ST_BAD_STOP   = 3'd3,
    ST_BAD_WORD   = 3'd4
  } status_e;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [CLK_W-1:0]   clk;
    status_e            fmt;
    logic               bad;
  } meta_t;

endpackage

// ===== rtl/core/uart_baud_divisor_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the
// pipeline is a chain of one-bit restoring division stages (16 for the
// divisor, 28 for the achieved speed). A stall on the output freezes every
// stage; nothing is lost or repeated. Reset clears all valid bits and the
// input clock register to zero.
// ----------------------------------------------------------------------------
// UART baud divisor check
// Computes the rounded 16x oversampling baud divisor for a requested line
// speed, checks the speed error, then parity, stop bits and word length.
// ----------------------------------------------------------------------------
module uart_baud_divisor_check #(
  parameter logic [31:0] DEFAULT_CLOCK_HZ = 32'd1843200
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_input_clock_hz_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] baud_rate_i,
  input  logic [1:0]  parity_mode_i,
  input  logic [1:0]  stop_bit_mode_i,
  input  logic [3:0]  word_length_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] divisor_o,
  output logic [2:0]  status_o
);

  localparam int SW = uartbd_pkg::SPEED_W;
  localparam int CW = uartbd_pkg::CLK_W;
  localparam int DW = uartbd_pkg::DIV_W;

  logic [uartbd_pkg::CFG_W-1:0] cfg_clk_q;
  logic                         adv;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_clk_q <= '0;
    end else if (cfg_valid_i) begin
      cfg_clk_q <= cfg_input_clock_hz_i;
    end
  end

  // Entry stage.
  logic [uartbd_pkg::CFG_W-1:0] clk_sel;
  logic [CW-1:0]                clk_sh;
  logic [SW-1:0]                num_d;
  uartbd_pkg::status_e          fmt_d;
  uartbd_pkg::meta_t            m0_d;

  always_comb begin
    clk_sel = (cfg_clk_q != '0) ? cfg_clk_q : DEFAULT_CLOCK_HZ;
    clk_sh  = clk_sel[uartbd_pkg::CFG_W-1:uartbd_pkg::OVS_SHIFT];
    num_d   = {{(SW-CW){1'b0}}, clk_sh} + {1'b0, baud_rate_i[SW-1:1]};
    priority if (parity_mode_i == uartbd_pkg::PARITY_UNSUPPORTED) begin
      fmt_d = uartbd_pkg::ST_BAD_PARITY;
    end else if (stop_bit_mode_i != uartbd_pkg::STOP_ONE &&
                 stop_bit_mode_i != uartbd_pkg::STOP_TWO) begin
      fmt_d = uartbd_pkg::ST_BAD_STOP;
    end else if (word_length_i < uartbd_pkg::WORD_MIN ||
                 word_length_i > uartbd_pkg::WORD_MAX) begin
      fmt_d = uartbd_pkg::ST_BAD_WORD;
    end else begin
      fmt_d = uartbd_pkg::ST_OK;
    end
    m0_d.speed = baud_rate_i;
    m0_d.clk   = clk_sh;
    m0_d.fmt   = fmt_d;
    m0_d.bad   = (baud_rate_i == '0);
  end

  logic              v0_q;
  uartbd_pkg::meta_t m0_q;
  logic [SW-1:0]     num0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0_q   <= m0_d;
      num0_q <= num_d;
    end
  end

  // Divisor: rounded quotient, one bit per stage after an overflow test.
  logic              v1_q [0:DW];
  uartbd_pkg::meta_t m1_q [0:DW];
  logic [SW-1:0]     r1_q [0:DW];
  logic [DW-1:0]     n1_q [0:DW];
  logic [DW-1:0]     q1_q [0:DW];
  logic [SW-1:0]     num_hi;
  uartbd_pkg::meta_t m1_in;

  always_comb begin
    num_hi    = {{(SW-DW){1'b0}}, num0_q[SW-1:DW]};
    m1_in     = m0_q;
    m1_in.bad = m0_q.bad | (num_hi >= m0_q.speed);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q[0] <= 1'b0;
    end else if (adv) begin
      v1_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q[0] <= m1_in;
      r1_q[0] <= num_hi;
      n1_q[0] <= num0_q[DW-1:0];
      q1_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div1
    logic [SW:0]   sh;
    logic          ge;
    logic [SW:0]   sub;
    logic [SW-1:0] r_d;

    always_comb begin
      sh  = {r1_q[k], n1_q[k][DW-1]};
      ge  = (sh >= {1'b0, m1_q[k].speed});
      sub = sh - {1'b0, m1_q[k].speed};
      r_d = ge ? sub[SW-1:0] : sh[SW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[k+1] <= 1'b0;
      end else if (adv) begin
        v1_q[k+1] <= v1_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        m1_q[k+1] <= m1_q[k];
        r1_q[k+1] <= r_d;
        n1_q[k+1] <= {n1_q[k][DW-2:0], 1'b0};
        q1_q[k+1] <= {q1_q[k][DW-2:0], ge};
      end
    end
  end

  // Achieved speed: shifted clock divided by the divisor, one bit per stage.
  logic              v2_q  [0:CW];
  uartbd_pkg::meta_t m2_q  [0:CW];
  logic [DW-1:0]     dv2_q [0:CW];
  logic [DW-1:0]     r2_q  [0:CW];
  logic [CW-1:0]     n2_q  [0:CW];
  logic [CW-1:0]     q2_q  [0:CW];
  uartbd_pkg::meta_t m2_in;

  always_comb begin
    m2_in     = m1_q[DW];
    m2_in.bad = m1_q[DW].bad | (q1_q[DW] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q[0] <= 1'b0;
    end else if (adv) begin
      v2_q[0] <= v1_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_q[0]  <= m2_in;
      dv2_q[0] <= q1_q[DW];
      r2_q[0]  <= '0;
      n2_q[0]  <= m1_q[DW].clk;
      q2_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_div2
    logic [DW:0]   sh;
    logic          ge;
    logic [DW:0]   sub;
    logic [DW-1:0] r_d;

    always_comb begin
      sh  = {r2_q[k], n2_q[k][CW-1]};
      ge  = (sh >= {1'b0, dv2_q[k]});
      sub = sh - {1'b0, dv2_q[k]};
      r_d = ge ? sub[DW-1:0] : sh[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[k+1] <= 1'b0;
      end else if (adv) begin
        v2_q[k+1] <= v2_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        m2_q[k+1]  <= m2_q[k];
        dv2_q[k+1] <= dv2_q[k];
        r2_q[k+1]  <= r_d;
        n2_q[k+1]  <= {n2_q[k][CW-2:0], 1'b0};
        q2_q[k+1]  <= {q2_q[k][CW-2:0], ge};
      end
    end
  end

  // Speed error magnitude.
  logic [SW-1:0]                 ach;
  logic [uartbd_pkg::DIFF_W-1:0] diff_d;
  logic                          vf_q;
  uartbd_pkg::meta_t             mf_q;
  logic [DW-1:0]                 dvf_q;
  logic [uartbd_pkg::DIFF_W-1:0] diff_q;

  always_comb begin
    ach    = {{(SW-CW){1'b0}}, q2_q[CW]};
    diff_d = (ach > m2_q[CW].speed) ? (ach - m2_q[CW].speed) : (m2_q[CW].speed - ach);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (adv) begin
      vf_q <= v2_q[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mf_q   <= m2_q[CW];
      dvf_q  <= dv2_q[CW];
      diff_q <= diff_d;
    end
  end

  // Tolerance test: the error exceeds speed/30 + 1 exactly when the error is
  // at least two and 30 times (error - 1) is above the speed.
  logic [uartbd_pkg::DIFF_W-1:0] dm1;
  logic [uartbd_pkg::PROD_W-1:0] tol_prod;
  logic                          tol_bad;
  logic                          bad_all;
  logic                          vo_q;
  logic [DW-1:0]                 div_q;
  uartbd_pkg::status_e           st_q;

  always_comb begin
    dm1      = diff_q - uartbd_pkg::DIFF_W'(1);
    tol_prod = {{(uartbd_pkg::PROD_W-uartbd_pkg::DIFF_W){1'b0}}, dm1}
               * uartbd_pkg::PROD_W'(uartbd_pkg::TOL_DIVISOR);
    tol_bad  = (diff_q >= uartbd_pkg::DIFF_W'(2)) &&
               (tol_prod > {{(uartbd_pkg::PROD_W-SW){1'b0}}, mf_q.speed});
    bad_all  = mf_q.bad | tol_bad;
  end

  assign adv = !vo_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q <= bad_all ? '0 : dvf_q;
      st_q  <= bad_all ? uartbd_pkg::ST_BAD_SPEED : mf_q.fmt;
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = vo_q;
  assign divisor_o   = div_q;
  assign status_o    = st_q;

endmodule
